@@ rtl/core/qtl_pkg.sv @@
// ----------------------------------------------------------------------------
// qtl_pkg: shared types and codes of the query token lexer
// Scan modes, result kinds, token type codes, character codes and the
// result record that travels from the decoder to the output queue.
// ----------------------------------------------------------------------------
package qtl_pkg;

  typedef enum logic [3:0] {
    SM_IDLE    = 4'd0,
    SM_HELD    = 4'd1,
    SM_STR     = 4'd2,
    SM_STR_ESC = 4'd3,
    SM_RGX     = 4'd4,
    SM_RGX_ESC = 4'd5,
    SM_NUM     = 4'd6,
    SM_IDENT   = 4'd7
  } scan_mode_t;

  typedef enum logic [1:0] {
    RK_TEXT  = 2'd0,
    RK_TOKEN = 2'd1,
    RK_ERROR = 2'd2
  } result_kind_t;

  localparam logic [4:0] TT_END        = 5'd0;
  localparam logic [4:0] TT_IDENT      = 5'd1;
  localparam logic [4:0] TT_NUMBER     = 5'd2;
  localparam logic [4:0] TT_STRING     = 5'd3;
  localparam logic [4:0] TT_REGEX      = 5'd4;
  localparam logic [4:0] TT_NE         = 5'd5;
  localparam logic [4:0] TT_NOT_GT     = 5'd6;
  localparam logic [4:0] TT_NOT_LT     = 5'd7;
  localparam logic [4:0] TT_SHL        = 5'd8;
  localparam logic [4:0] TT_SHR        = 5'd9;
  localparam logic [4:0] TT_LE         = 5'd10;
  localparam logic [4:0] TT_GE         = 5'd11;
  localparam logic [4:0] TT_SCOPE      = 5'd12;
  localparam logic [4:0] TT_PUNCT_BASE = 5'd13;

  localparam int PUNCT_COUNT = 19;
  localparam logic [7:0] PUNCT_SET [PUNCT_COUNT] = '{
    "[", "]", "(", ")", "=", "<", ">", "&", "|", ":",
    "@", ";", ".", ",", "{", "}", "+", "*", "?"
  };

  localparam logic [7:0] CH_BANG       = "!";
  localparam logic [7:0] CH_LT         = "<";
  localparam logic [7:0] CH_GT         = ">";
  localparam logic [7:0] CH_COLON      = ":";
  localparam logic [7:0] CH_MINUS      = "-";
  localparam logic [7:0] CH_UNDERSCORE = "_";
  localparam logic [7:0] CH_SLASH      = "/";
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_EQ         = "=";
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_LF         = 8'h0A;

  localparam int MAX_RESULTS = 4;

  typedef struct packed {
    scan_mode_t  mode;
    logic [7:0]  held;
    logic        err;
  } qtl_ctl_t;

  typedef struct packed {
    result_kind_t kind;
    logic [4:0]   ttype;
    logic [23:0]  start;
    logic [7:0]   ch;
  } result_t;

endpackage

@@ rtl/core/query_token_lexer_core.sv @@
// ----------------------------------------------------------------------------
// query_token_lexer_core: streaming tokenizer for a query language
// Takes one byte of query text per beat and emits text, token and error
// results, followed by an END token on the final byte.
// ----------------------------------------------------------------------------
// A byte is taken in every cycle in which the result queue is empty or is
// handing out its last entry, so a byte that causes several results (up to
// four) holds back the input while the single output port moves one result
// per beat, unless out_stall holds it. The decision for a byte is made in the
// cycle it is accepted, between the lexer state registers and the result
// queue; after the final byte all offsets restart at zero.
module query_token_lexer_core #(
  parameter int OFFSET_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        in_is_final,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [4:0]  out_token_type,
  output logic [23:0] out_start_offset,
  output logic [7:0]  out_text_char,
  output logic        out_run_last
);
  import qtl_pkg::*;

  qtl_ctl_t               ctl_r, ctl_nxt;
  logic [OFFSET_BITS-1:0] ts_r, ts_nxt;
  logic [OFFSET_BITS-1:0] ofs_r, ofs_nxt;
  result_t [MAX_RESULTS-1:0] slots;
  logic [2:0]             count;
  logic                   load_ok;
  logic                   accept;

  assign in_stall = !load_ok;
  assign accept   = in_valid && load_ok;

  qtl_decode #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_decode (
    .ctl_i   (ctl_r),
    .ts_i    (ts_r),
    .at_i    (ofs_r),
    .char_i  (in_char_byte),
    .fin_i   (in_is_final),
    .slots_o (slots),
    .count_o (count),
    .ctl_nxt (ctl_nxt),
    .ts_nxt  (ts_nxt),
    .ofs_nxt (ofs_nxt)
  );

  qtl_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .load_i           (accept),
    .slots_i          (slots),
    .count_i          (count),
    .load_ok_o        (load_ok),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_token_type   (out_token_type),
    .out_start_offset (out_start_offset),
    .out_text_char    (out_text_char),
    .out_run_last     (out_run_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.mode <= SM_IDLE;
      ctl_r.held <= 8'd0;
      ctl_r.err  <= 1'b0;
      ts_r       <= '0;
      ofs_r      <= '0;
    end else if (accept) begin
      ctl_r <= ctl_nxt;
      ts_r  <= ts_nxt;
      ofs_r <= ofs_nxt;
    end
  end

`ifndef SYNTHESIS
  // The final byte returns the lexer to its reset state.
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_is_final |=> (ofs_r == '0) && (ctl_r.mode == SM_IDLE) && !ctl_r.err)
    else $error("lexer state not cleared after final byte");

  // Any other byte moves the offset on by one.
  a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_is_final |=> ofs_r == $past(ofs_r) + OFFSET_BITS'(1))
    else $error("byte offset did not advance");

  // Once an error is seen the lexer sits idle until the final byte.
  a_error_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.err |-> ctl_r.mode == SM_IDLE)
    else $error("scan mode active after error");

  // An empty result queue never holds back the input.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result queue");

  // A final byte always leaves at least its END result behind.
  a_final_results: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_is_final |=> out_valid)
    else $error("final byte produced no result");
`endif

endmodule

@@ rtl/core/qtl_decode.sv @@
// ----------------------------------------------------------------------------
// qtl_decode: per-byte lexer decision logic
// From the lexer state and one byte, works out the ordered list of results
// (at most four) and the state that follows the byte.
// ----------------------------------------------------------------------------
module qtl_decode #(
  parameter int OFFSET_BITS = 24
) (
  input  qtl_pkg::qtl_ctl_t                   ctl_i,
  input  logic [OFFSET_BITS-1:0]              ts_i,
  input  logic [OFFSET_BITS-1:0]              at_i,
  input  logic [7:0]                          char_i,
  input  logic                                fin_i,
  output qtl_pkg::result_t [qtl_pkg::MAX_RESULTS-1:0] slots_o,
  output logic [2:0]                          count_o,
  output qtl_pkg::qtl_ctl_t                   ctl_nxt,
  output logic [OFFSET_BITS-1:0]              ts_nxt,
  output logic [OFFSET_BITS-1:0]              ofs_nxt
);
  import qtl_pkg::*;

  localparam int NCAND = 7;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE) || (c == CH_MINUS);
  endfunction

  // Nineteen independent compares against the punctuator table.
  function automatic logic [4:0] punct_type(input logic [7:0] c);
    logic [4:0] t;
    t = TT_END;
    for (int i = 0; i < PUNCT_COUNT; i++) begin
      if (PUNCT_SET[i] == c) t = TT_PUNCT_BASE + 5'(i);
    end
    return t;
  endfunction

  function automatic logic [4:0] pair_type(input logic [7:0] h, input logic [7:0] c);
    logic [4:0] t;
    t = TT_END;
    if (h == CH_BANG && c == CH_EQ)        t = TT_NE;
    else if (h == CH_BANG && c == CH_GT)   t = TT_NOT_GT;
    else if (h == CH_BANG && c == CH_LT)   t = TT_NOT_LT;
    else if (h == CH_LT && c == CH_LT)     t = TT_SHL;
    else if (h == CH_GT && c == CH_GT)     t = TT_SHR;
    else if (h == CH_LT && c == CH_EQ)     t = TT_LE;
    else if (h == CH_GT && c == CH_EQ)     t = TT_GE;
    else if (h == CH_COLON && c == CH_COLON) t = TT_SCOPE;
    return t;
  endfunction

  function automatic result_t mk(input result_kind_t k, input logic [4:0] t,
                                 input logic [OFFSET_BITS-1:0] s, input logic [7:0] c);
    result_t r;
    r.kind  = k;
    r.ttype = t;
    r.start = 24'(s);
    r.ch    = c;
    return r;
  endfunction

  scan_mode_t             mode_a;
  logic [7:0]             held_a;
  logic                   err_a;
  logic [OFFSET_BITS-1:0] ts_new;
  logic [OFFSET_BITS-1:0] err_ofs;
  logic [OFFSET_BITS-1:0] at_next;
  logic                   fresh;
  logic                   pre_en, close_en, text_en, tok2_en, err_en, fin_en;
  logic [7:0]             pre_ch;
  logic [4:0]             close_type, tok2_type, fin_type, pt;
  result_kind_t           fin_kind;
  result_t [NCAND-1:0]    cand;
  logic [NCAND-1:0]       cand_en;

  assign at_next = at_i + OFFSET_BITS'(1);
  assign pt      = pair_type(ctl_i.held, char_i);

  // First pass: the byte against the current mode, then a fresh start from idle
  // or where the previous token has just been closed.
  always_comb begin
    mode_a     = ctl_i.mode;
    held_a     = ctl_i.held;
    err_a      = ctl_i.err;
    ts_new     = ts_i;
    err_ofs    = ts_i;
    fresh      = 1'b0;
    pre_en     = 1'b0;
    pre_ch     = CH_BANG;
    close_en   = 1'b0;
    close_type = TT_END;
    text_en    = 1'b0;
    tok2_en    = 1'b0;
    tok2_type  = TT_END;
    err_en     = 1'b0;
    if (!ctl_i.err) begin
      unique case (ctl_i.mode)
        SM_HELD: begin
          if (pt != TT_END) begin
            pre_en    = (ctl_i.held == CH_BANG);
            pre_ch    = CH_BANG;
            text_en   = 1'b1;
            tok2_en   = 1'b1;
            tok2_type = pt;
            mode_a    = SM_IDLE;
          end else if (ctl_i.held == CH_MINUS && is_digit(char_i)) begin
            pre_en  = 1'b1;
            pre_ch  = CH_MINUS;
            text_en = 1'b1;
            mode_a  = SM_NUM;
          end else if (ctl_i.held == CH_BANG || ctl_i.held == CH_MINUS) begin
            err_en  = 1'b1;
            err_ofs = ts_i;
          end else begin
            close_en   = 1'b1;
            close_type = punct_type(ctl_i.held);
            fresh      = 1'b1;
          end
        end
        SM_STR: begin
          if (char_i == CH_QUOTE) begin
            close_en   = 1'b1;
            close_type = TT_STRING;
            mode_a     = SM_IDLE;
          end else if (char_i == CH_BACKSLASH && !fin_i) begin
            mode_a = SM_STR_ESC;
          end else begin
            text_en = 1'b1;
          end
        end
        SM_STR_ESC: begin
          text_en = 1'b1;
          mode_a  = SM_STR;
        end
        SM_RGX: begin
          if (char_i == CH_SLASH) begin
            close_en   = 1'b1;
            close_type = TT_REGEX;
            mode_a     = SM_IDLE;
          end else begin
            text_en = 1'b1;
            if (char_i == CH_BACKSLASH) mode_a = SM_RGX_ESC;
          end
        end
        SM_RGX_ESC: begin
          text_en = 1'b1;
          mode_a  = SM_RGX;
        end
        SM_NUM: begin
          if (is_digit(char_i)) begin
            text_en = 1'b1;
          end else begin
            close_en   = 1'b1;
            close_type = TT_NUMBER;
            fresh      = 1'b1;
          end
        end
        SM_IDENT: begin
          if (is_ident_char(char_i)) begin
            text_en = 1'b1;
          end else begin
            close_en   = 1'b1;
            close_type = TT_IDENT;
            fresh      = 1'b1;
          end
        end
        SM_IDLE: fresh = 1'b1;
        default: fresh = 1'b1;
      endcase

      if (fresh) begin
        mode_a = SM_IDLE;
        if (!is_space(char_i)) begin
          ts_new = at_i;
          if (char_i == CH_BANG || char_i == CH_LT || char_i == CH_GT ||
              char_i == CH_COLON || char_i == CH_MINUS) begin
            mode_a  = SM_HELD;
            held_a  = char_i;
            // The angle brackets and the colon start a token whatever follows.
            text_en = (char_i == CH_LT) || (char_i == CH_GT) || (char_i == CH_COLON);
          end else if (punct_type(char_i) != TT_END) begin
            text_en   = 1'b1;
            tok2_en   = 1'b1;
            tok2_type = punct_type(char_i);
          end else if (char_i == CH_QUOTE) begin
            mode_a = SM_STR;
          end else if (char_i == CH_SLASH) begin
            mode_a = SM_RGX;
          end else if (is_digit(char_i)) begin
            text_en = 1'b1;
            mode_a  = SM_NUM;
          end else if (is_alpha(char_i) || char_i == CH_UNDERSCORE) begin
            text_en = 1'b1;
            mode_a  = SM_IDENT;
          end else begin
            err_en  = 1'b1;
            err_ofs = at_i;
          end
        end
      end

      if (err_en) begin
        err_a  = 1'b1;
        mode_a = SM_IDLE;
      end
    end
  end

  // Final byte: close whatever token is still open, or flag a lone ! or - as an error.
  always_comb begin
    fin_en   = 1'b0;
    fin_kind = RK_TOKEN;
    fin_type = TT_END;
    if (fin_i && !err_a) begin
      unique case (mode_a)
        SM_HELD: begin
          fin_en = 1'b1;
          if (held_a == CH_BANG || held_a == CH_MINUS) fin_kind = RK_ERROR;
          else fin_type = punct_type(held_a);
        end
        SM_STR, SM_STR_ESC: begin
          fin_en   = 1'b1;
          fin_type = TT_STRING;
        end
        SM_RGX, SM_RGX_ESC: begin
          fin_en   = 1'b1;
          fin_type = TT_REGEX;
        end
        SM_NUM: begin
          fin_en   = 1'b1;
          fin_type = TT_NUMBER;
        end
        SM_IDENT: begin
          fin_en   = 1'b1;
          fin_type = TT_IDENT;
        end
        SM_IDLE: fin_en = 1'b0;
        default: fin_en = 1'b0;
      endcase
    end
  end

  always_comb begin
    cand[0] = mk(RK_TEXT, TT_END, ts_i, pre_ch);
    cand[1] = mk(RK_TOKEN, close_type, ts_i, 8'd0);
    cand[2] = mk(RK_TEXT, TT_END, ts_new, char_i);
    cand[3] = mk(RK_TOKEN, tok2_type, ts_new, 8'd0);
    cand[4] = mk(RK_ERROR, TT_END, err_ofs, 8'd0);
    cand[5] = mk(fin_kind, fin_type, ts_new, 8'd0);
    cand[6] = mk(RK_TOKEN, TT_END, at_next, 8'd0);
    cand_en = {fin_i, fin_en, err_en, tok2_en, text_en, close_en, pre_en};
  end

  // Pack the enabled candidates, in order, into the result slots.
  always_comb begin
    slots_o = '0;
    count_o = 3'd0;
    for (int i = 0; i < NCAND; i++) begin
      if (cand_en[i] && count_o < 3'(MAX_RESULTS)) begin
        slots_o[count_o[1:0]] = cand[i];
        count_o = count_o + 3'd1;
      end
    end
  end

  always_comb begin
    if (fin_i) begin
      ctl_nxt.mode = SM_IDLE;
      ctl_nxt.held = 8'd0;
      ctl_nxt.err  = 1'b0;
      ts_nxt       = '0;
      ofs_nxt      = '0;
    end else begin
      ctl_nxt.mode = mode_a;
      ctl_nxt.held = held_a;
      ctl_nxt.err  = err_a;
      ts_nxt       = ts_new;
      ofs_nxt      = at_next;
    end
  end

endmodule

@@ rtl/core/qtl_emit.sv @@
// ----------------------------------------------------------------------------
// qtl_emit: result queue of the query token lexer
// Holds the results of one byte and hands them out one per beat unless stalled.
// A new set can be loaded in the cycle in which the last one leaves.
// ----------------------------------------------------------------------------
module qtl_emit (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      load_i,
  input  qtl_pkg::result_t [qtl_pkg::MAX_RESULTS-1:0] slots_i,
  input  logic [2:0]                                count_i,
  output logic                                      load_ok_o,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic [1:0]                                out_result_kind,
  output logic [4:0]                                out_token_type,
  output logic [23:0]                               out_start_offset,
  output logic [7:0]                                out_text_char,
  output logic                                      out_run_last
);
  import qtl_pkg::*;

  result_t [MAX_RESULTS-1:0] slot_r;
  logic [2:0]                cnt_r;
  logic                      pop;

  assign pop       = (cnt_r != 3'd0) && !out_stall;
  assign load_ok_o = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else if (load_i) begin
      cnt_r <= count_i;
    end else if (pop) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      slot_r <= slots_i;
    end else if (pop) begin
      slot_r <= {result_t'('0), slot_r[MAX_RESULTS-1:1]};
    end
  end

  assign out_valid        = (cnt_r != 3'd0);
  assign out_result_kind  = slot_r[0].kind;
  assign out_token_type   = slot_r[0].ttype;
  assign out_start_offset = slot_r[0].start;
  assign out_text_char    = slot_r[0].ch;
  assign out_run_last     = (cnt_r == 3'd1);

endmodule
